>>> rtl/core/tseg_pkg.sv
// Shared constants for the trend segmenter: direction codes, register
// indexes, default widths and output queue sizing. No dependencies.
package tseg_pkg;

  localparam int DEF_SAMPLE_WIDTH = 32;
  localparam int DEF_INDEX_WIDTH  = 32;

  localparam int TOL_W    = 31;
  localparam int FIRST_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INDEX = 1'b1;

  localparam int DIR_W = 2;
  localparam logic [DIR_W-1:0] DIR_FLAT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RISE  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_FALL  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UNSET = 2'd3;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0] count;
  } tseg_push_t;

endpackage

>>> rtl/core/trend_segmenter_absolute.sv
// Top level of the trend segmenter: configuration registers, segmenting
// core and result queue. Depends on tseg_pkg, tseg_core, tseg_outq.
//
//   channel | direction | handshake          | payload
//   in_     | into      | in_valid/in_stall  | in_sample, in_final_sample
//   out_    | out of    | out_valid/out_stall| begin, end, delta, run_last
//   cfg_    | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One sample per cycle sustained while in_stall stays low: the input register
// feeds the direction and segment update, which writes up to two results
// into a four-entry result queue. Results pass through the input register
// and the result queue before they appear. in_stall rises while the input
// register holds a sample and the queue has fewer than two free entries.
// Synchronous reset clears the stream state and both configuration registers.
module trend_segmenter_absolute #(
  parameter int SAMPLE_WIDTH = tseg_pkg::DEF_SAMPLE_WIDTH,
  parameter int INDEX_WIDTH  = tseg_pkg::DEF_INDEX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_final_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [INDEX_WIDTH-1:0]              out_segment_begin,
  output logic [INDEX_WIDTH-1:0]              out_segment_end,
  output logic signed [SAMPLE_WIDTH:0]        out_segment_delta,
  output logic                                out_run_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tseg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tseg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tseg_pkg::*;

  localparam int RES_W = 2 * INDEX_WIDTH + SAMPLE_WIDTH + 2;

  logic [TOL_W-1:0]   tol_r, tol_nxt;
  logic [FIRST_W-1:0] first_r, first_nxt;
  tseg_push_t         push_ctl;
  logic               q_room;
  logic [RES_W-1:0]   push_data0, push_data1, q_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    tol_nxt   = tol_r;
    first_nxt = first_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOLERANCE:   tol_nxt   = cfg_data[TOL_W-1:0];
        REG_FIRST_INDEX: first_nxt = cfg_data[FIRST_W-1:0];
        default:         tol_nxt   = tol_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= '0;
      first_r <= '0;
    end else begin
      tol_r   <= tol_nxt;
      first_r <= first_nxt;
    end
  end

  tseg_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .INDEX_WIDTH  (INDEX_WIDTH),
    .RES_W        (RES_W)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_final_sample (in_final_sample),
    .tolerance       (tol_r),
    .first_index     (first_r),
    .push_room       (q_room),
    .push_ctl        (push_ctl),
    .push_data0      (push_data0),
    .push_data1      (push_data1)
  );

  tseg_outq #(
    .RES_W (RES_W)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (push_ctl.count),
    .push_data0 (push_data0),
    .push_data1 (push_data1),
    .push_room  (q_room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (q_data)
  );

  assign out_segment_begin = q_data[RES_W-1 -: INDEX_WIDTH];
  assign out_segment_end   = q_data[RES_W-1-INDEX_WIDTH -: INDEX_WIDTH];
  assign out_segment_delta = q_data[SAMPLE_WIDTH+1:1];
  assign out_run_last      = q_data[0];

endmodule

>>> rtl/core/tseg_outq.sv
// Result queue of the trend segmenter: takes up to two results per cycle,
// hands one out per transaction. Depends on tseg_pkg.
module tseg_outq #(
  parameter int RES_W = 98
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_count,
  input  logic [RES_W-1:0] push_data0,
  input  logic [RES_W-1:0] push_data1,
  output logic             push_room,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [RES_W-1:0] out_data
);
  import tseg_pkg::*;

  logic [RES_W-1:0]      mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt, wptr_p1;
  logic [OUTQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign pop       = (cnt_r != '0) && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rptr_r];
  assign push_room = (cnt_r <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign wptr_p1   = wptr_r + OUTQ_PTR_W'(1);

  always_comb begin
    wptr_nxt = wptr_r + OUTQ_PTR_W'(push_count);
    rptr_nxt = pop ? rptr_r + OUTQ_PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + OUTQ_CNT_W'(push_count) - OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem_r[wptr_r] <= push_data0;
    end
    if (push_count == 2'd2) begin
      mem_r[wptr_p1] <= push_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/tseg_core.sv
// Segmenting datapath: input register, direction decision, segment state
// and result formation. Depends on tseg_pkg.
module tseg_core #(
  parameter int SAMPLE_WIDTH = tseg_pkg::DEF_SAMPLE_WIDTH,
  parameter int INDEX_WIDTH  = tseg_pkg::DEF_INDEX_WIDTH,
  parameter int RES_W        = 2 * INDEX_WIDTH + SAMPLE_WIDTH + 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample,
  input  logic                             in_final_sample,
  input  logic [tseg_pkg::TOL_W-1:0]       tolerance,
  input  logic [tseg_pkg::FIRST_W-1:0]     first_index,
  input  logic                             push_room,
  output tseg_pkg::tseg_push_t             push_ctl,
  output logic [RES_W-1:0]                 push_data0,
  output logic [RES_W-1:0]                 push_data1
);
  import tseg_pkg::*;

  localparam int CW = (SAMPLE_WIDTH + 1 > TOL_W + 1) ? SAMPLE_WIDTH + 1 : TOL_W + 1;

  logic                           vld_r, vld_nxt;
  logic signed [SAMPLE_WIDTH-1:0] smp_r;
  logic                           fin_r;

  logic signed [SAMPLE_WIDTH-1:0] prev_r, prev_nxt, start_r, start_nxt;
  logic [INDEX_WIDTH-1:0]         sidx_r, sidx_nxt, idx_r, idx_nxt;
  logic [DIR_W-1:0]               cur_r, cur_nxt, pdir_r, pdir_nxt;
  logic                           started_r, started_nxt;

  logic                           fire;
  logic [63:0]                    fi_ext;
  logic [INDEX_WIDTH-1:0]         fi;
  logic signed [SAMPLE_WIDTH:0]   step_diff;
  logic signed [CW-1:0]           diff_x, tol_x, ntol_x;
  logic [DIR_W-1:0]               dir_new, pdir_eff;
  logic                           change;
  logic signed [SAMPLE_WIDTH-1:0] u_prev, u_start;
  logic [INDEX_WIDTH-1:0]         u_sidx, u_idx;
  logic signed [SAMPLE_WIDTH:0]   chg_delta, fin_delta;
  logic [RES_W-1:0]               res_chg, res_fin;

  assign fire     = vld_r && push_room;
  assign in_stall = vld_r && !push_room;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  assign fi_ext = {32'd0, first_index};
  assign fi     = fi_ext[INDEX_WIDTH-1:0];

  always_comb begin
    step_diff = {smp_r[SAMPLE_WIDTH-1], smp_r} - {prev_r[SAMPLE_WIDTH-1], prev_r};
    diff_x    = CW'(step_diff);
    tol_x     = CW'(tolerance);
    ntol_x    = -tol_x;
    if ((diff_x > 0 && cur_r == DIR_RISE) || diff_x > tol_x) begin
      dir_new = DIR_RISE;
    end else if ((diff_x < 0 && cur_r == DIR_FALL) || diff_x < ntol_x) begin
      dir_new = DIR_FALL;
    end else begin
      dir_new = DIR_FLAT;
    end
    pdir_eff = (pdir_r == DIR_UNSET) ? dir_new : pdir_r;
    change   = started_r && (dir_new != pdir_eff);

    if (!started_r) begin
      u_prev  = smp_r;
      u_start = smp_r;
      u_sidx  = fi;
      u_idx   = fi;
    end else begin
      u_prev  = smp_r;
      u_start = change ? prev_r : start_r;
      u_sidx  = change ? idx_r : sidx_r;
      u_idx   = idx_r + INDEX_WIDTH'(1);
    end

    chg_delta = {prev_r[SAMPLE_WIDTH-1], prev_r} - {start_r[SAMPLE_WIDTH-1], start_r};
    fin_delta = {u_prev[SAMPLE_WIDTH-1], u_prev} - {u_start[SAMPLE_WIDTH-1], u_start};
    res_chg = {sidx_r + INDEX_WIDTH'(1), idx_r + INDEX_WIDTH'(1), chg_delta, !fin_r};
    res_fin = {u_sidx + INDEX_WIDTH'(1), u_idx + INDEX_WIDTH'(1), fin_delta, 1'b1};

    push_ctl.count = fire ? (2'(change) + 2'(fin_r)) : 2'd0;
    push_data0     = change ? res_chg : res_fin;
    push_data1     = res_fin;

    prev_nxt    = prev_r;
    start_nxt   = start_r;
    sidx_nxt    = sidx_r;
    idx_nxt     = idx_r;
    cur_nxt     = cur_r;
    pdir_nxt    = pdir_r;
    started_nxt = started_r;
    if (fire) begin
      if (fin_r) begin
        prev_nxt    = '0;
        start_nxt   = '0;
        sidx_nxt    = '0;
        idx_nxt     = '0;
        cur_nxt     = DIR_FLAT;
        pdir_nxt    = DIR_UNSET;
        started_nxt = 1'b0;
      end else begin
        prev_nxt    = u_prev;
        start_nxt   = u_start;
        sidx_nxt    = u_sidx;
        idx_nxt     = u_idx;
        cur_nxt     = started_r ? dir_new : DIR_FLAT;
        pdir_nxt    = started_r ? dir_new : DIR_UNSET;
        started_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      smp_r <= in_sample;
      fin_r <= in_final_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      prev_r    <= '0;
      start_r   <= '0;
      sidx_r    <= '0;
      idx_r     <= '0;
      cur_r     <= DIR_FLAT;
      pdir_r    <= DIR_UNSET;
      started_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      prev_r    <= prev_nxt;
      start_r   <= start_nxt;
      sidx_r    <= sidx_nxt;
      idx_r     <= idx_nxt;
      cur_r     <= cur_nxt;
      pdir_r    <= pdir_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

>>> sim/trend_segmenter_absolute_test.sv
// Self-checking testbench for trend_segmenter_absolute: directed and random sample
// streams with random idling and stalls, checked against an in-bench segment predictor.
// Depends on tseg_pkg and the trend_segmenter_absolute RTL.
module trend_segmenter_absolute_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tseg_pkg::*;

  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int IW = DEF_INDEX_WIDTH;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED = 100;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    logic [IW-1:0]        seg_begin;
    logic [IW-1:0]        seg_end;
    logic signed [SW:0]   delta;
    logic                 run_last;
  } segment_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SW-1:0]     in_sample = '0;
  logic                     in_final_sample = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IW-1:0]            out_segment_begin;
  logic [IW-1:0]            out_segment_end;
  logic signed [SW:0]       out_segment_delta;
  logic                     out_run_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  trend_segmenter_absolute DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_final_sample   (in_final_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_segment_begin (out_segment_begin),
    .out_segment_end   (out_segment_end),
    .out_segment_delta (out_segment_delta),
    .out_run_last      (out_run_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state and register copies
  logic [TOL_W-1:0]     tolerance_reg = '0;
  logic [IW-1:0]        first_index_reg = '0;
  logic signed [SW-1:0] last_sample = '0;
  logic signed [SW-1:0] seg_start_val = '0;
  logic [IW-1:0]        seg_start_idx = '0;
  logic [IW-1:0]        sample_idx = '0;
  logic [DIR_W-1:0]     cur_dir = DIR_FLAT;
  logic [DIR_W-1:0]     prev_dir = DIR_UNSET;
  logic                 stream_live = 1'b0;

  segment_t expected_segments[$];
  int error_count = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_off_len = 0;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTED)
      $display("%0t ERROR %s: got %h expected %h", $realtime, field, got, want);
    error_count++;
  endtask

  function automatic segment_t close_segment();
    segment_t seg;
    seg.seg_begin = seg_start_idx + 1'b1;
    seg.seg_end   = sample_idx + 1'b1;
    seg.delta     = {last_sample[SW-1], last_sample} - {seg_start_val[SW-1], seg_start_val};
    seg.run_last  = 1'b0;
    return seg;
  endfunction

  task automatic predict_segments(input logic signed [SW-1:0] s, input logic fin);
    segment_t found[$];
    longint step;
    longint tol;
    if (!stream_live) begin
      stream_live   = 1'b1;
      last_sample   = s;
      seg_start_val = s;
      seg_start_idx = first_index_reg;
      sample_idx    = first_index_reg;
      cur_dir       = DIR_FLAT;
      prev_dir      = DIR_UNSET;
    end else begin
      step = longint'(s) - longint'(last_sample);
      tol  = longint'(tolerance_reg);
      if ((step > 0 && cur_dir == DIR_RISE) || step > tol)
        cur_dir = DIR_RISE;
      else if ((step < 0 && cur_dir == DIR_FALL) || step < -tol)
        cur_dir = DIR_FALL;
      else
        cur_dir = DIR_FLAT;
      if (prev_dir == DIR_UNSET)
        prev_dir = cur_dir;
      if (cur_dir != prev_dir) begin
        found.insert(found.size(), close_segment());
        seg_start_val = last_sample;
        seg_start_idx = sample_idx;
      end
      prev_dir    = cur_dir;
      last_sample = s;
      sample_idx  = sample_idx + 1'b1;
    end
    if (fin) begin
      found.insert(found.size(), close_segment());
      last_sample   = '0;
      seg_start_val = '0;
      seg_start_idx = '0;
      sample_idx    = '0;
      cur_dir       = DIR_FLAT;
      prev_dir      = DIR_UNSET;
      stream_live   = 1'b0;
    end
    if (found.size() > 0)
      found[found.size()-1].run_last = 1'b1;
    foreach (found[i])
      expected_segments.insert(expected_segments.size(), found[i]);
  endtask

  task automatic check_segment();
    segment_t want;
    if (expected_segments.size() == 0) begin
      report_mismatch("unexpected result, segment_end", out_segment_end, '0);
      return;
    end
    want = expected_segments.pop_front();
    if (out_segment_begin !== want.seg_begin)
      report_mismatch("segment_begin", out_segment_begin, want.seg_begin);
    if (out_segment_end !== want.seg_end)
      report_mismatch("segment_end", out_segment_end, want.seg_end);
    if (out_segment_delta !== want.delta)
      report_mismatch("segment_delta", out_segment_delta, want.delta);
    if (out_run_last !== want.run_last)
      report_mismatch("run_last", out_run_last, want.run_last);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      predict_segments(in_sample, in_final_sample);
    if (rst_n && out_valid === 1'b1 && !out_stall)
      check_segment();
  end

  always @(posedge clk) begin
    if (hold_off_len > 0) begin
      out_stall <= 1'b1;
      hold_off_len--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) === 1'b1 || (out_valid && !out_stall) === 1'b1 ||
          (cfg_valid && cfg_ready) === 1'b1)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(input logic signed [SW-1:0] s, input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_final_sample <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_TOLERANCE)
      tolerance_reg = data[TOL_W-1:0];
    else
      first_index_reg = data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] tol,
                            input logic [CFG_DATA_W-1:0] first);
    wait_for_results();
    write_register(REG_TOLERANCE, tol);
    write_register(REG_FIRST_INDEX, first);
  endtask

  function automatic logic signed [SW-1:0] next_sample(input logic signed [SW-1:0] prev);
    logic signed [SW-1:0] tolv;
    logic signed [SW-1:0] offset;
    tolv   = {1'b0, tolerance_reg};
    offset = $urandom_range(0, tolerance_reg);
    case ($urandom_range(10))
      0: return $urandom;
      1: return prev;
      2: return prev + tolv + 1;
      3: return prev - tolv - 1;
      4: return prev + tolv;
      5: return prev - tolv;
      6: return prev + $urandom_range(1, 3);
      7: return prev - $urandom_range(1, 3);
      8: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: return $urandom_range(1) ? prev + offset : prev - offset;
    endcase
  endfunction

  task automatic send_stream(input int len);
    logic signed [SW-1:0] s;
    s = ($urandom_range(5) == 0) ? ($urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN) : $urandom;
    for (int k = 0; k < len; k++) begin
      send_sample(s, k == len - 1);
      s = next_sample(s);
    end
  endtask

  task automatic run_random_traffic(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(7) == 0) begin
        send_sample($urandom, $urandom_range(3) == 0);
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_stream(len);
        sent += len;
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_sample('0, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN + 1, 1'b1);
  endtask

  task automatic test_tolerance_trends();
    set_config(32'd100, 32'hFFFF_FFFE);
    send_sample(32'sd5, 1'b1);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd50, 1'b0);
    send_sample(32'sd200, 1'b0);
    send_sample(32'sd250, 1'b0);
    send_sample(32'sd250, 1'b0);
    send_sample(32'sd100, 1'b0);
    send_sample(32'sd99, 1'b0);
    send_sample(32'sd99, 1'b0);
    send_sample(32'sd199, 1'b1);
  endtask

  task automatic test_register_masking();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX - 1, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [CFG_DATA_W-1:0] tol,
                                   input logic [CFG_DATA_W-1:0] first, input int items);
    set_config(tol, first);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    run_random_traffic(items);
  endtask

  task automatic test_output_hold_off();
    set_config($urandom_range(0, 1000), $urandom);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_off_len  = 300;
    run_random_traffic(50);
  endtask

  task automatic test_sender_pause();
    logic signed [SW-1:0] s;
    in_idle_pct   = 26;
    out_stall_pct = 26;
    s = $urandom;
    for (int k = 0; k < 30; k++) begin
      send_sample(s, k == 29);
      s = next_sample(s);
      if (k % 10 == 9)
        wait_for_results();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_tolerance_trends();
    test_register_masking();
    test_random_phase(0, 0, 32'd0, 32'd0, 290);
    test_random_phase(64, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 290);
    test_random_phase(0, 64, $urandom_range(1, 1000), $urandom, 290);
    test_random_phase(26, 26, $urandom, 32'hFFFF_FFF0, 290);
    test_output_hold_off();
    test_sender_pause();

    wait_for_results();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tseg_pkg.sv
rtl/core/tseg_outq.sv
rtl/core/tseg_core.sv
rtl/core/trend_segmenter_absolute.sv
sim/trend_segmenter_absolute_test.sv
